// File: src/icd_pkg.sv
// Package for the indexed circular deque: sizes, codes, control word format
// and the microcode program. No dependencies.
package icd_pkg;

  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int unsigned STEP_W     = 3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } icd_status_e;

  // datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_LATCH,
    OP_SETUP,
    OP_RD_VAL,
    OP_CAPTURE,
    OP_MOVE,
    OP_PUT,
    OP_COMMIT,
    OP_RESPOND
  } icd_op_e;

  // jump condition: taken -> target, else next step
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_ITEM,
    C_ERR,
    C_INSERT,
    C_MORE,
    C_OUT_BUSY
  } icd_cond_e;

  typedef logic [STEP_W-1:0] icd_step_t;

  localparam icd_step_t STEP_LATCH   = icd_step_t'(0);
  localparam icd_step_t STEP_SETUP   = icd_step_t'(1);
  localparam icd_step_t STEP_RD_VAL  = icd_step_t'(2);
  localparam icd_step_t STEP_CAPTURE = icd_step_t'(3);
  localparam icd_step_t STEP_MOVE    = icd_step_t'(4);
  localparam icd_step_t STEP_PUT     = icd_step_t'(5);
  localparam icd_step_t STEP_COMMIT  = icd_step_t'(6);
  localparam icd_step_t STEP_RESPOND = icd_step_t'(7);

  typedef struct packed {
    icd_op_e   op;
    icd_cond_e cond;
    icd_step_t target;
  } icd_cw_t;

  typedef struct packed {
    logic no_item;
    logic err;
    logic insert;
    logic more;
    logic out_busy;
  } icd_flags_t;

  // Microcode ROM. The last step falls through to step 0 by wrap.
  function automatic icd_cw_t ucode_word(input icd_step_t step);
    icd_cw_t cw;
    case (step)
      STEP_LATCH:   cw = '{op: OP_LATCH,   cond: C_NO_ITEM,  target: STEP_LATCH};
      STEP_SETUP:   cw = '{op: OP_SETUP,   cond: C_ERR,      target: STEP_RESPOND};
      STEP_RD_VAL:  cw = '{op: OP_RD_VAL,  cond: C_INSERT,   target: STEP_MOVE};
      STEP_CAPTURE: cw = '{op: OP_CAPTURE, cond: C_NEVER,    target: STEP_LATCH};
      STEP_MOVE:    cw = '{op: OP_MOVE,    cond: C_MORE,     target: STEP_MOVE};
      STEP_PUT:     cw = '{op: OP_PUT,     cond: C_NEVER,    target: STEP_LATCH};
      STEP_COMMIT:  cw = '{op: OP_COMMIT,  cond: C_NEVER,    target: STEP_LATCH};
      STEP_RESPOND: cw = '{op: OP_RESPOND, cond: C_OUT_BUSY, target: STEP_RESPOND};
      default:      cw = '{op: OP_LATCH,   cond: C_NO_ITEM,  target: STEP_LATCH};
    endcase
    return cw;
  endfunction

endpackage

// File: src/icd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module icd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/icd_seq.sv
// Microcode sequencer: step counter, control ROM lookup, conditional jumps.
// Depends on icd_pkg.
module icd_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  icd_pkg::icd_flags_t flags_i,
  output icd_pkg::icd_cw_t    cw_o
);

  icd_pkg::icd_step_t step_q, step_d;
  icd_pkg::icd_cw_t   cw;
  logic               take;

  always_comb begin
    cw = icd_pkg::ucode_word(step_q);
    case (cw.cond)
      icd_pkg::C_NEVER:    take = 1'b0;
      icd_pkg::C_NO_ITEM:  take = flags_i.no_item;
      icd_pkg::C_ERR:      take = flags_i.err;
      icd_pkg::C_INSERT:   take = flags_i.insert;
      icd_pkg::C_MORE:     take = flags_i.more;
      icd_pkg::C_OUT_BUSY: take = flags_i.out_busy;
      default:             take = 1'b0;
    endcase
    step_d = take ? cw.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= icd_pkg::STEP_LATCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign cw_o = cw;

endmodule

// File: src/icd_datapath.sv
// Datapath: item latch, head/count registers, shift pointers, slot RAM
// port drive and output register. Depends on icd_pkg.
module icd_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  icd_pkg::icd_cw_t                    cw_i,
  output icd_pkg::icd_flags_t                 flags_o,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [icd_pkg::POS_W-1:0]           position_i,
  input  logic signed [icd_pkg::VALUE_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [icd_pkg::VALUE_W-1:0]  removed_value_o,
  output logic [icd_pkg::COUNT_W-1:0]         count_o,
  output logic [icd_pkg::STATUS_W-1:0]        status_o,
  output logic                                ram_we_o,
  output logic [icd_pkg::ADDR_W-1:0]          ram_waddr_o,
  output logic [icd_pkg::DATA_WIDTH-1:0]      ram_wdata_o,
  output logic                                ram_re_o,
  output logic [icd_pkg::ADDR_W-1:0]          ram_raddr_o,
  input  logic [icd_pkg::DATA_WIDTH-1:0]      ram_rdata_i
);

  // control state
  logic [icd_pkg::ADDR_W-1:0]     head_q, head_d;
  logic [icd_pkg::CNT_W-1:0]      used_q, used_d;
  logic                           pend_q, pend_d;
  logic                           out_valid_q, out_valid_d;
  // item and shift payload
  logic                           kind_q, kind_d;
  logic [icd_pkg::POS_W-1:0]      pos_q, pos_d;
  logic [icd_pkg::DATA_WIDTH-1:0] value_q, value_d;
  logic [icd_pkg::DATA_WIDTH-1:0] removed_q, removed_d;
  icd_pkg::icd_status_e           status_q, status_d;
  logic                           front_q, front_d;
  logic                           up_q, up_d;
  logic [icd_pkg::ADDR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [icd_pkg::ADDR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [icd_pkg::ADDR_W-1:0]     tgt_q, tgt_d;
  logic [icd_pkg::CNT_W-1:0]      n_q, n_d;
  logic [icd_pkg::VALUE_W-1:0]    out_removed_q, out_removed_d;
  logic [icd_pkg::COUNT_W-1:0]    out_count_q, out_count_d;
  icd_pkg::icd_status_e           out_status_q, out_status_d;

  logic [icd_pkg::CMP_W-1:0]  pos_w, used_w;
  logic [icd_pkg::ADDR_W-1:0] pos_a, used_a;
  logic                       front;
  logic                       out_busy;
  icd_pkg::icd_status_e       status_c;

  assign pos_w    = icd_pkg::CMP_W'(pos_q);
  assign used_w   = icd_pkg::CMP_W'(used_q);
  assign pos_a    = icd_pkg::ADDR_W'(pos_w);
  assign used_a   = icd_pkg::ADDR_W'(used_q);
  assign front    = pos_w < (used_w >> 1);
  assign out_busy = out_valid_q && out_stall_i;

  // full check ahead of range check
  always_comb begin
    status_c = icd_pkg::ST_OK;
    if (kind_q == icd_pkg::KIND_INSERT) begin
      if (used_q == icd_pkg::CNT_W'(icd_pkg::CAPACITY)) begin
        status_c = icd_pkg::ST_FULL;
      end else if (pos_w > used_w) begin
        status_c = icd_pkg::ST_RANGE;
      end
    end else if (pos_w >= used_w) begin
      status_c = icd_pkg::ST_RANGE;
    end
  end

  always_comb begin
    head_d        = head_q;
    used_d        = used_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q;
    kind_d        = kind_q;
    pos_d         = pos_q;
    value_d       = value_q;
    removed_d     = removed_q;
    status_d      = status_q;
    front_d       = front_q;
    up_d          = up_q;
    rd_ptr_d      = rd_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    tgt_d         = tgt_q;
    n_d           = n_q;
    out_removed_d = out_removed_q;
    out_count_d   = out_count_q;
    out_status_d  = out_status_q;
    ram_we_o      = 1'b0;
    ram_waddr_o   = wr_ptr_q;
    ram_wdata_o   = ram_rdata_i;
    ram_re_o      = 1'b0;
    ram_raddr_o   = rd_ptr_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (cw_i.op)
      icd_pkg::OP_LATCH: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          pos_d   = position_i;
          value_d = icd_pkg::DATA_WIDTH'($unsigned(value_i));
        end
      end
      icd_pkg::OP_SETUP: begin
        status_d  = status_c;
        removed_d = '0;
        pend_d    = 1'b0;
        front_d   = front;
        tgt_d     = head_q + pos_a;
        if (kind_q == icd_pkg::KIND_INSERT) begin
          if (front) begin
            // head steps back one; front elements slide toward it
            tgt_d    = head_q + pos_a - 1'b1;
            rd_ptr_d = head_q;
            up_d     = 1'b1;
            n_d      = icd_pkg::CNT_W'(pos_w);
          end else begin
            rd_ptr_d = head_q + used_a - 1'b1;
            up_d     = 1'b0;
            n_d      = icd_pkg::CNT_W'(used_w - pos_w);
          end
        end else begin
          if (front) begin
            rd_ptr_d = head_q + pos_a - 1'b1;
            up_d     = 1'b0;
            n_d      = icd_pkg::CNT_W'(pos_w);
          end else begin
            rd_ptr_d = head_q + pos_a + 1'b1;
            up_d     = 1'b1;
            n_d      = icd_pkg::CNT_W'(used_w - pos_w - 1'b1);
          end
        end
      end
      icd_pkg::OP_RD_VAL: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = head_q + pos_a;
      end
      icd_pkg::OP_CAPTURE: begin
        removed_d = ram_rdata_i;
      end
      icd_pkg::OP_MOVE: begin
        // write back the element read last cycle while reading the next
        ram_we_o = pend_q;
        if (n_q != '0) begin
          ram_re_o = 1'b1;
          rd_ptr_d = up_q ? rd_ptr_q + 1'b1 : rd_ptr_q - 1'b1;
          wr_ptr_d = up_q ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
          n_d      = n_q - 1'b1;
          pend_d   = 1'b1;
        end else begin
          pend_d   = 1'b0;
        end
      end
      icd_pkg::OP_PUT: begin
        if (kind_q == icd_pkg::KIND_INSERT) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = tgt_q;
          ram_wdata_o = value_q;
        end
      end
      icd_pkg::OP_COMMIT: begin
        if (kind_q == icd_pkg::KIND_INSERT) begin
          used_d = used_q + 1'b1;
          if (front_q) begin
            head_d = head_q - 1'b1;
          end
        end else begin
          used_d = used_q - 1'b1;
          if (front_q) begin
            head_d = head_q + 1'b1;
          end
        end
      end
      icd_pkg::OP_RESPOND: begin
        if (!out_busy) begin
          out_valid_d   = 1'b1;
          out_removed_d = icd_pkg::VALUE_W'(removed_q);
          out_count_d   = icd_pkg::COUNT_W'(used_q);
          out_status_d  = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      used_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      used_q      <= used_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    pos_q         <= pos_d;
    value_q       <= value_d;
    removed_q     <= removed_d;
    status_q      <= status_d;
    front_q       <= front_d;
    up_q          <= up_d;
    rd_ptr_q      <= rd_ptr_d;
    wr_ptr_q      <= wr_ptr_d;
    tgt_q         <= tgt_d;
    n_q           <= n_d;
    out_removed_q <= out_removed_d;
    out_count_q   <= out_count_d;
    out_status_q  <= out_status_d;
  end

  assign in_stall_o      = (cw_i.op != icd_pkg::OP_LATCH);
  assign out_valid_o     = out_valid_q;
  assign removed_value_o = out_removed_q;
  assign count_o         = out_count_q;
  assign status_o        = out_status_q;

  assign flags_o.no_item  = !in_valid_i;
  assign flags_o.err      = (status_c != icd_pkg::ST_OK);
  assign flags_o.insert   = (kind_q == icd_pkg::KIND_INSERT);
  assign flags_o.more     = (n_q != '0);
  assign flags_o.out_busy = out_busy;

endmodule

// File: src/indexed_circular_deque_core.sv
// Top level of the indexed circular deque: sequencer, datapath, slot RAM.
// Depends on icd_pkg, icd_seq, icd_datapath, icd_ram.
//
// Indexed circular deque. A list of up to CAPACITY elements lives in a slot
// RAM as a ring that starts at a head pointer. Each item inserts a value at a
// list position or removes the value at a position; the block then shifts by
// one slot whichever side of the position is shorter (the front side when
// position < count/2, moving the head pointer too). Every item returns one
// result: the removed value (zero for an insert or an error), the count after
// the item and a status (ok, insert while full, position out of range). An
// error item changes nothing. Items are handled one at a time: the block
// takes no new item until the last one is through. A valid item shifts m
// elements, m being the number on the shorter side (at most about
// CAPACITY/2); an error item skips the shift. The shift loop moves one
// element per cycle through the RAM's single read and single write port
// (each element is written back in the cycle after it is read). The result
// sits in an output register, so the next item is taken while an earlier
// result still waits; a result only blocks the block if the previous one
// has not been taken yet. The RAM contents are not reset; only written
// slots are ever read.

module indexed_circular_deque_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [icd_pkg::POS_W-1:0]           position_i,
  input  logic signed [icd_pkg::VALUE_W-1:0]  value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [icd_pkg::VALUE_W-1:0]  removed_value_o,
  output logic [icd_pkg::COUNT_W-1:0]         count_o,
  output logic [icd_pkg::STATUS_W-1:0]        status_o
);

  icd_pkg::icd_cw_t               cw;
  icd_pkg::icd_flags_t            flags;
  logic                           ram_we;
  logic [icd_pkg::ADDR_W-1:0]     ram_waddr;
  logic [icd_pkg::DATA_WIDTH-1:0] ram_wdata;
  logic                           ram_re;
  logic [icd_pkg::ADDR_W-1:0]     ram_raddr;
  logic [icd_pkg::DATA_WIDTH-1:0] ram_rdata;

  // step counter and control ROM; jumps on datapath flags
  icd_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw)
  );

  // head/count, shift pointers, item latch, output register
  icd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cw_i            (cw),
    .flags_o         (flags),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_value_o (removed_value_o),
    .count_o         (count_o),
    .status_o        (status_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  // element slots
  icd_ram #(
    .WIDTH (icd_pkg::DATA_WIDTH),
    .DEPTH (icd_pkg::CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: src/icd_checker.sv
// Port-level checks for indexed_circular_deque_core, plus the bind that
// attaches them. Depends on icd_pkg.
module icd_port_checks (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                kind_i,
  input logic [icd_pkg::POS_W-1:0]           position_i,
  input logic signed [icd_pkg::VALUE_W-1:0]  value_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [icd_pkg::VALUE_W-1:0]  removed_value_o,
  input logic [icd_pkg::COUNT_W-1:0]         count_o,
  input logic [icd_pkg::STATUS_W-1:0]        status_o
);

  // held result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(removed_value_o) && $stable(count_o) && $stable(status_o)))
    else $error("result changed while stalled");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (icd_pkg::CMP_W'(count_o) <= icd_pkg::CMP_W'(icd_pkg::CAPACITY)))
    else $error("count above capacity");

  // full status only when the list really is full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == icd_pkg::ST_FULL) |->
      (icd_pkg::CMP_W'(count_o) == icd_pkg::CMP_W'(icd_pkg::CAPACITY)))
    else $error("full status with room left");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != icd_pkg::ST_OK) |-> (removed_value_o == '0))
    else $error("error result carries a value");

endmodule

bind indexed_circular_deque_core icd_port_checks u_icd_checker (.*);
